[rtl/spq_pkg.sv]
// Shared types and codes for the sorted priority queue.
package spq_pkg;

  typedef enum logic {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_e;

  localparam int unsigned CountOutW = 5;

  typedef struct packed {
    logic enq;
    logic deq;
  } spq_ctl_t;

endpackage

[rtl/spq_cell.sv]
// One storage cell of the sorted shift chain.
module spq_cell import spq_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  spq_ctl_t                     ctl_i,
  input  logic signed [VALUE_BITS-1:0] new_val_i,
  input  logic                         left_keep_i,
  input  logic signed [VALUE_BITS-1:0] left_val_i,
  input  logic                         left_valid_i,
  input  logic signed [VALUE_BITS-1:0] right_val_i,
  input  logic                         right_valid_i,
  output logic                         keep_o,
  output logic signed [VALUE_BITS-1:0] val_o,
  output logic                         valid_o
);

  logic signed [VALUE_BITS-1:0] val_q, val_d;
  logic                         valid_q, valid_d;

  // Entry stays put on insert when it ranks at or above the new value
  assign keep_o  = valid_q && (val_q >= new_val_i);
  assign val_o   = val_q;
  assign valid_o = valid_q;

  always_comb begin
    val_d   = val_q;
    valid_d = valid_q;
    if (ctl_i.enq) begin
      if (!keep_o) begin
        if (left_keep_i) begin
          val_d   = new_val_i;
          valid_d = 1'b1;
        end else begin
          val_d   = left_val_i;
          valid_d = left_valid_i;
        end
      end
    end else if (ctl_i.deq) begin
      val_d   = right_val_i;
      valid_d = right_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

[rtl/sorted_priority_queue.sv]
// Sorted priority queue built from a chain of shifting compare cells.
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+----------------------------------
//   in      | sink      | in_valid_i / in_stall_o | command_i, value_i
//   out     | source    | out_valid_o/out_stall_i | removed_value_o, count_o,
//           |           |                         | is_empty_o, is_full_o, fault_o
//
// One transaction per cycle unless stalled; every cell compares and shifts
// in the same cycle. The result sits in an output register in the cycle after
// acceptance; a new transaction is taken whenever that register is empty or
// being drained. Reset empties the chain at once through per-cell valid flags.
// An out stall holds the result and stalls the input only while it persists.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [VALUE_BITS-1:0] removed_value_o,
  output logic [CountOutW-1:0]         count_o,
  output logic                         is_empty_o,
  output logic                         is_full_o,
  output logic                         fault_o
);

  localparam int unsigned OccW = $clog2(DEPTH + 1);

  logic                         in_acc;
  logic                         is_enq, is_deq, empty_now, full_now, fault_now;
  spq_ctl_t                     ctl;
  logic [OccW-1:0]              occ_q, occ_d;
  logic [DEPTH-1:0]             keep, valid;
  logic signed [VALUE_BITS-1:0] cell_val [DEPTH];
  logic [OccW+CountOutW-1:0]    occ_ext;

  logic                         out_valid_q;
  logic signed [VALUE_BITS-1:0] removed_q;
  logic [CountOutW-1:0]         count_q;
  logic                         empty_q, full_q, fault_q;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign empty_now = !valid[0];
  assign full_now  = valid[DEPTH-1];
  assign is_enq    = cmd_e'(command_i) == CMD_ENQ;
  assign is_deq    = cmd_e'(command_i) == CMD_DEQ;
  assign fault_now = (is_enq && full_now) || (is_deq && empty_now);
  assign ctl.enq   = in_acc && is_enq && !full_now;
  assign ctl.deq   = in_acc && is_deq && !empty_now;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                         l_keep, l_valid, r_valid;
    logic signed [VALUE_BITS-1:0] l_val, r_val;
    if (i == 0) begin : g_first
      assign l_keep  = 1'b1;
      assign l_val   = '0;
      assign l_valid = 1'b0;
    end else begin : g_mid
      assign l_keep  = keep[i-1];
      assign l_val   = cell_val[i-1];
      assign l_valid = valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_val   = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_val   = cell_val[i+1];
      assign r_valid = valid[i+1];
    end
    spq_cell #(.VALUE_BITS(VALUE_BITS)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .new_val_i     (value_i),
      .left_keep_i   (l_keep),
      .left_val_i    (l_val),
      .left_valid_i  (l_valid),
      .right_val_i   (r_val),
      .right_valid_i (r_valid),
      .keep_o        (keep[i]),
      .val_o         (cell_val[i]),
      .valid_o       (valid[i])
    );
  end

  always_comb begin
    occ_d = occ_q;
    if (ctl.enq) begin
      occ_d = occ_q + OccW'(1);
    end else if (ctl.deq) begin
      occ_d = occ_q - OccW'(1);
    end
  end

  assign occ_ext = {{CountOutW{1'b0}}, occ_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      removed_q <= ctl.deq ? cell_val[0] : '0;
      count_q   <= occ_ext[CountOutW-1:0];
      empty_q   <= occ_d == '0;
      full_q    <= occ_d == OccW'(DEPTH);
      fault_q   <= fault_now;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign count_o         = count_q;
  assign is_empty_o      = empty_q;
  assign is_full_o       = full_q;
  assign fault_o         = fault_q;

  a_occ_matches_cells : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid) == 32'(occ_q))
    else $error("occupancy differs from number of valid cells");

  a_occ_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OccW'(DEPTH))
    else $error("occupancy above depth");

  a_fault_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && fault_now) |=> (occ_q == $past(occ_q)) && $stable(valid))
    else $error("refused transaction changed the queue");

  a_head_ranks_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[1] |-> (cell_val[0] >= cell_val[1]))
    else $error("head is not the largest entry");

endmodule
